// ----- rtl/rws_pkg.sv -----
// Shared types and constants for the roulette wheel selector.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package rws_pkg;

	// Wheel geometry and fitness format.
	localparam int POP_MAX      = 256;
	localparam int FITNESS_BITS = 16;
	localparam int IDX_W        = $clog2(POP_MAX);
	localparam int POP_W        = $clog2(POP_MAX + 1);
	localparam int DRAW_W       = 8;
	localparam int SUM_W        = FITNESS_BITS + IDX_W + 1;

	// Configuration port.
	localparam int CFG_POP_W = 9;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// Register indexes, taken from the word address.
	localparam logic REG_POP_SIZE    = 1'b0;
	localparam logic REG_AVG_FITNESS = 1'b1;

	// Request kinds.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write;
		logic start;
		logic step;
		logic load;
	} rws_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_target;
		logic walk_last;
	} rws_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rws_regs.sv -----
// Configuration registers behind the APB-style port: pop_size and avg_fitness.
// Depends on rws_pkg.
`default_nettype none

module rws_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rws_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rws_pkg::DATA_W-1:0]    pwdata,
	output logic      [rws_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic      [rws_pkg::CFG_POP_W-1:0] pop_size_q,
	output logic      [rws_pkg::FITNESS_BITS-1:0] avg_fitness_q
);
	import rws_pkg::*;

	logic reg_idx;
	logic wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q    <= CFG_POP_W'(POP_MAX);
			avg_fitness_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POP_SIZE:    pop_size_q    <= pwdata[CFG_POP_W-1:0];
				REG_AVG_FITNESS: avg_fitness_q <= pwdata[FITNESS_BITS-1:0];
			endcase
		end
	end

	// Read data follows the address.
	always_comb begin
		unique case (reg_idx)
			REG_POP_SIZE:    prdata = DATA_W'(pop_size_q);
			REG_AVG_FITNESS: prdata = DATA_W'(avg_fitness_q);
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/rws_ctrl.sv -----
// Controller state machine: input and output handshakes and walk sequencing.
// Depends on rws_pkg; drives the datapath through rws_cmd_t.
`default_nettype none

module rws_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               req_type,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire rws_pkg::rws_stat_t stat,
	output rws_pkg::rws_cmd_t       cmd
);
	import rws_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   take;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// Commands decoded from the current state and the handshakes.
	always_comb begin
		cmd.write = take && (req_type == REQ_WRITE);
		cmd.start = take && (req_type == REQ_SELECT);
		cmd.step  = (state_q == ST_WALK);
		cmd.load  = (state_q == ST_FINISH) && out_free;
	end

	// State and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= stat.zero_target ? ST_FINISH : ST_WALK;
					end
				end
				ST_WALK: begin
					if (stat.walk_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rws_datapath.sv -----
// Datapath: fitness memory, wheel pointer, running sum, target and pick logic.
// Depends on rws_pkg; sequenced by rws_ctrl.
`default_nettype none

module rws_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rws_pkg::rws_cmd_t                cmd,
	output rws_pkg::rws_stat_t                    stat,
	input  wire logic [rws_pkg::CFG_POP_W-1:0]    pop_size,
	input  wire logic [rws_pkg::FITNESS_BITS-1:0] avg_fitness,
	input  wire logic [rws_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [rws_pkg::FITNESS_BITS-1:0] fitness_value,
	input  wire logic [rws_pkg::DRAW_W-1:0]       random_draw,
	input  wire logic [rws_pkg::DRAW_W-1:0]       fallback_draw,
	input  wire logic                             avoid_previous,
	input  wire logic [rws_pkg::IDX_W-1:0]        previous_pick,
	output logic      [rws_pkg::IDX_W-1:0]        picked_index
);
	import rws_pkg::*;

	logic [FITNESS_BITS-1:0] fit_mem [POP_MAX];
	logic [FITNESS_BITS-1:0] rdata_q;

	logic [IDX_W-1:0]  ptr_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  target_q;
	logic [POP_W-1:0]  visited_q;
	logic [DRAW_W-1:0] fallback_q;
	logic              avoid_q;
	logic [IDX_W-1:0]  prev_q;

	logic [POP_W-1:0] n;
	logic [POP_W-1:0] n_m1;
	logic [IDX_W-1:0] ptr_norm;
	logic [POP_W-1:0] ptr_inc;
	logic [IDX_W-1:0] ptr_next;
	logic [IDX_W-1:0] rd_addr;
	logic [SUM_W-1:0] sum_new;
	logic [POP_W-1:0] visited_inc;
	logic [IDX_W-1:0] pick_raw;
	logic [IDX_W-1:0] pick_fb;
	logic [IDX_W-1:0] pick;

	// Effective wheel size: zero counts as one, large values saturate.
	always_comb begin
		priority if (pop_size == '0) begin
			n = POP_W'(1);
		end else if (POP_W'(pop_size) > POP_W'(POP_MAX)) begin
			n = POP_W'(POP_MAX);
		end else begin
			n = POP_W'(pop_size);
		end
	end
	assign n_m1 = n - POP_W'(1);

	// Pointer arithmetic with wrap at the wheel size.
	assign ptr_norm = (POP_W'(ptr_q) >= n) ? '0 : ptr_q;
	assign ptr_inc  = POP_W'(ptr_q) + POP_W'(1);
	assign ptr_next = (ptr_inc >= n) ? '0 : ptr_inc[IDX_W-1:0];
	assign rd_addr  = cmd.start ? ptr_norm : ptr_next;

	// One accumulate and compare per visited entry.
	assign sum_new     = sum_q + SUM_W'(rdata_q);
	assign visited_inc = visited_q + POP_W'(1);
	assign stat.walk_last   = (sum_new >= target_q) || (visited_inc == n);
	assign stat.zero_target = (avg_fitness == '0);

	// The pick is the entry before the pointer, replaced on an avoided repeat.
	assign pick_raw = (ptr_q == '0) ? n_m1[IDX_W-1:0] : ptr_q - IDX_W'(1);
	assign pick_fb  = (POP_W'(fallback_q) >= n) ? n_m1[IDX_W-1:0] : IDX_W'(fallback_q);
	assign pick     = (avoid_q && (pick_raw == prev_q)) ? pick_fb : pick_raw;

	// Fitness memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			fit_mem[entry_index] <= fitness_value;
		end
		rdata_q <= fit_mem[rd_addr];
	end

	// The wheel pointer persists across selections.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.start) begin
			ptr_q <= ptr_norm;
		end else if (cmd.step) begin
			ptr_q <= ptr_next;
		end
	end

	// Walk state and the captured request fields.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sum_q      <= '0;
			visited_q  <= '0;
			target_q   <= SUM_W'(POP_W'(random_draw) + POP_W'(1)) * SUM_W'(avg_fitness);
			fallback_q <= fallback_draw;
			avoid_q    <= avoid_previous;
			prev_q     <= previous_pick;
		end else if (cmd.step) begin
			sum_q     <= sum_new;
			visited_q <= visited_inc;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			picked_index <= pick;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/roulette_wheel_selector.sv -----
// Top level of the roulette wheel selector: registers, controller, datapath.
// Depends on rws_pkg, rws_regs, rws_ctrl and rws_datapath.
//
//   Channel   Handshake          Payload
//   input     in_valid/in_ready  req_type, entry_index, fitness_value, random_draw,
//                                fallback_draw, avoid_previous, previous_pick
//   output    out_valid/out_ready picked_index
//   config    psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// A select request visits k entries (0 when avg_fitness is zero, at most the effective
// wheel size), one per cycle through the single read port of the fitness memory.
// Reset clears the wheel pointer and avg_fitness and sets pop_size to 256; fitness entries are undefined until written.
// A pending result is held in the output register while the next request is accepted; a
// finished selection waits only if that register is still full.
`default_nettype none

module roulette_wheel_selector (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [rws_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [rws_pkg::FITNESS_BITS-1:0] fitness_value,
	input  wire logic [rws_pkg::DRAW_W-1:0]       random_draw,
	input  wire logic [rws_pkg::DRAW_W-1:0]       fallback_draw,
	input  wire logic                             avoid_previous,
	input  wire logic [rws_pkg::IDX_W-1:0]        previous_pick,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [rws_pkg::IDX_W-1:0]        picked_index,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rws_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [rws_pkg::DATA_W-1:0]       pwdata,
	output logic      [rws_pkg::DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import rws_pkg::*;

	logic [CFG_POP_W-1:0]    pop_size;
	logic [FITNESS_BITS-1:0] avg_fitness;
	rws_cmd_t                cmd;
	rws_stat_t               stat;

	rws_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pop_size_q    (pop_size),
		.avg_fitness_q (avg_fitness)
	);

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rws_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.pop_size       (pop_size),
		.avg_fitness    (avg_fitness),
		.entry_index    (entry_index),
		.fitness_value  (fitness_value),
		.random_draw    (random_draw),
		.fallback_draw  (fallback_draw),
		.avoid_previous (avoid_previous),
		.previous_pick  (previous_pick),
		.picked_index   (picked_index)
	);

`ifndef NO_ASSERTIONS
	// No new request is taken while a walk or a result load is under way.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && (cmd.step || cmd.load)))
		else $error("request accepted while a selection is in progress");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// A result appears only after a load from the datapath.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load))
		else $error("result valid without a load");
`endif

endmodule

`default_nettype wire

// ----- verif/roulette_wheel_selector_test.sv -----
// Self-checking testbench for the roulette wheel selector: random and directed requests,
// APB register phases and a scoreboard that predicts every pick.
// Depends on rws_pkg and the roulette_wheel_selector RTL.
module roulette_wheel_selector_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rws_pkg::*;

	// One request as it appears on the input ports.
	typedef struct packed {
		logic                    req_type;
		logic [IDX_W-1:0]        entry_index;
		logic [FITNESS_BITS-1:0] fitness_value;
		logic [DRAW_W-1:0]       random_draw;
		logic [DRAW_W-1:0]       fallback_draw;
		logic                    avoid_previous;
		logic [IDX_W-1:0]        previous_pick;
	} wheel_req_t;

	// Predicts picks from the accepted requests and checks the picks that come out.
	class pick_scoreboard;
		logic [FITNESS_BITS-1:0] fitness_table [POP_MAX];
		int                      wheel_ptr;
		logic [CFG_POP_W-1:0]    pop_size_reg;
		logic [FITNESS_BITS-1:0] avg_fitness_reg;
		logic [IDX_W-1:0]        expected_picks [$];
		int                      mismatches;

		function new();
			wheel_ptr = 0;
			pop_size_reg = CFG_POP_W'(POP_MAX);
			avg_fitness_reg = '0;
			mismatches = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] ERROR: %s", $realtime, msg);
			mismatches++;
		endtask

		function void set_reg(input logic idx, input logic [DATA_W-1:0] value);
			if (idx == REG_POP_SIZE) begin
				pop_size_reg = value[CFG_POP_W-1:0];
			end else begin
				avg_fitness_reg = value[FITNESS_BITS-1:0];
			end
		endfunction

		// Zero entries act as one, and anything above the table saturates.
		function int active_size();
			int n;
			n = int'(pop_size_reg);
			if (n == 0) n = 1;
			if (n > POP_MAX) n = POP_MAX;
			return n;
		endfunction

		// Walks the wheel from the current pointer; ptr_after is where the pointer ends up.
		function logic [IDX_W-1:0] spin(input logic [DRAW_W-1:0] draw,
				input logic [DRAW_W-1:0] fallback, input logic avoid,
				input logic [IDX_W-1:0] prev, output int ptr_after);
			int     n;
			int     ptr;
			int     visited;
			int     pick;
			longint target;
			longint total;
			n = active_size();
			ptr = (wheel_ptr >= n) ? 0 : wheel_ptr;
			target = (longint'(draw) + 1) * longint'(avg_fitness_reg);
			total = 0;
			visited = 0;
			while (total < target && visited < n) begin
				total += longint'(fitness_table[ptr]);
				visited++;
				ptr++;
				if (ptr >= n) ptr = 0;
			end
			pick = (ptr == 0) ? n - 1 : ptr - 1;
			if (avoid && pick == int'(prev)) begin
				pick = (int'(fallback) >= n) ? n - 1 : int'(fallback);
			end
			ptr_after = ptr;
			return pick[IDX_W-1:0];
		endfunction

		// The pick that a select with this draw would make now, before any avoidance.
		function logic [IDX_W-1:0] preview_pick(input logic [DRAW_W-1:0] draw);
			int unused_ptr;
			return spin(draw, '0, 1'b0, '0, unused_ptr);
		endfunction

		function void note_request(input wheel_req_t r);
			int ptr_after;
			if (r.req_type == REQ_WRITE) begin
				fitness_table[r.entry_index] = r.fitness_value;
			end else begin
				expected_picks.push_back(spin(r.random_draw, r.fallback_draw,
					r.avoid_previous, r.previous_pick, ptr_after));
				wheel_ptr = ptr_after;
			end
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction

		task check_pick(input logic [IDX_W-1:0] got);
			logic [IDX_W-1:0] want;
			if (expected_picks.size() == 0) begin
				report_mismatch($sformatf("pick %0d arrived with none expected", got));
			end else begin
				want = expected_picks.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("picked_index %0d, expected %0d", got, want));
				end
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	wheel_req_t           cur;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     picked_index;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	pick_scoreboard sb = new();
	int  requests_sent;
	int  send_gap_pct;
	bit  no_idle;
	bit  hold_outputs;

	roulette_wheel_selector u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (cur.req_type),
		.entry_index    (cur.entry_index),
		.fitness_value  (cur.fitness_value),
		.random_draw    (cur.random_draw),
		.fallback_draw  (cur.fallback_draw),
		.avoid_previous (cur.avoid_previous),
		.previous_pick  (cur.previous_pick),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.picked_index   (picked_index),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run time.
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Check every pick the moment it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_pick(picked_index);
	end

	// Result side: random stall bursts, and one long hold when the sender asks for it.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_outputs) begin
				out_ready = 1'b0;
				repeat (600) @(negedge clk);
				hold_outputs = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Offers one request and waits for it to be taken; may leave a gap afterwards.
	task automatic send(input wheel_req_t r);
		cur = r;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
		requests_sent++;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// Stops offering requests and waits until every pick is out and the block is quiet.
	task automatic quiesce();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle.
	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
		paddr = {idx, 2'b00};
		pwdata = value;
		pwrite = 1'b1;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		sb.set_reg(idx, value);
	endtask

	function automatic wheel_req_t write_item(input int idx, input int value);
		wheel_req_t r;
		r.req_type = REQ_WRITE;
		r.entry_index = idx[IDX_W-1:0];
		r.fitness_value = value[FITNESS_BITS-1:0];
		r.random_draw = DRAW_W'($urandom);
		r.fallback_draw = DRAW_W'($urandom);
		r.avoid_previous = 1'($urandom);
		r.previous_pick = IDX_W'($urandom);
		return r;
	endfunction

	function automatic wheel_req_t select_item(input int draw, input int fallback,
			input bit avoid, input int prev);
		wheel_req_t r;
		r.req_type = REQ_SELECT;
		r.entry_index = IDX_W'($urandom);
		r.fitness_value = FITNESS_BITS'($urandom);
		r.random_draw = draw[DRAW_W-1:0];
		r.fallback_draw = fallback[DRAW_W-1:0];
		r.avoid_previous = avoid;
		r.previous_pick = prev[IDX_W-1:0];
		return r;
	endfunction

	// Mostly draws below the wheel size, half the time aimed at the pick to avoid.
	function automatic wheel_req_t random_request(input int write_pct);
		wheel_req_t r;
		int         draw;
		int         prev;
		int         fit;
		if ($urandom_range(0, 99) < write_pct) begin
			case ($urandom_range(0, 7))
				0: fit = 0;
				1: fit = 'hFFFF;
				default: fit = $urandom_range(0, 'hFFFF);
			endcase
			r = write_item($urandom_range(0, POP_MAX - 1), fit);
		end else begin
			draw = ($urandom_range(0, 6) != 0) ? $urandom_range(0, sb.active_size() - 1)
				: $urandom_range(0, 255);
			prev = $urandom_range(0, 1) ? int'(sb.preview_pick(DRAW_W'(draw)))
				: $urandom_range(0, 255);
			r = select_item(draw, $urandom_range(0, 255), 1'($urandom_range(0, 1)), prev);
		end
		return r;
	endfunction

	// Stimulus.
	initial begin
		int pop;
		int avg;
		int phase_len;
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cur = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		requests_sent = 0;
		send_gap_pct = 25;
		no_idle = 1'b0;
		hold_outputs = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero average straight after reset: nothing is visited, the pick is the last entry unless avoided.
		send(select_item(0, 0, 1'b0, 0));
		send(select_item(255, 255, 1'b1, 255));
		send(select_item(17, 3, 1'b1, 255));

		// Fill the whole table so that no walk can read an unwritten entry.
		for (int i = 0; i < POP_MAX; i++) begin
			send(write_item(i, (i == 0) ? 'hFFFF : (i == 1) ? 0 : $urandom_range(0, 'hFFFF)));
		end
		send(write_item(255, 0));

		// Full wheel at the largest average: the huge target of the largest draw walks every entry.
		quiesce();
		write_reg(REG_POP_SIZE, 256);
		write_reg(REG_AVG_FITNESS, 'hFFFF);
		send(select_item(255, 0, 1'b0, 0));
		send(select_item(0, 0, 1'b0, 0));
		send(select_item(200, 255, 1'b1, int'(sb.preview_pick(200))));

		// Zero size acts as one; the pointer restarts and the fallback is clamped.
		quiesce();
		write_reg(REG_POP_SIZE, 0);
		write_reg(REG_AVG_FITNESS, 1);
		send(select_item(0, 200, 1'b1, 0));
		send(select_item(255, 0, 1'b0, 0));

		// Oversized wheel saturates at the table size.
		quiesce();
		write_reg(REG_POP_SIZE, 511);
		write_reg(REG_AVG_FITNESS, 30000);
		send(select_item(5, 0, 1'b0, 0));
		send(select_item(255, 255, 1'b1, int'(sb.preview_pick(255))));

		// Two entries, moderate average.
		quiesce();
		write_reg(REG_POP_SIZE, 2);
		write_reg(REG_AVG_FITNESS, 100);
		send(write_item(0, 50));
		send(write_item(1, 200));
		send(select_item(0, 1, 1'b1, int'(sb.preview_pick(0))));
		send(select_item(1, 9, 1'b1, int'(sb.preview_pick(1))));
		send(select_item(3, 0, 1'b0, 0));

		// Random phases, each with its own wheel setting.
		phase = 0;
		while (requests_sent < 1550) begin
			quiesce();
			case ($urandom_range(0, 9))
				0: pop = 0;
				1: pop = $urandom_range(257, 511);
				2: pop = 256;
				3: pop = $urandom_range(1, 256);
				default: pop = $urandom_range(1, 32);
			endcase
			case ($urandom_range(0, 7))
				0: avg = 0;
				1: avg = 'hFFFF;
				2: avg = $urandom_range(0, 'hFFFF);
				default: avg = $urandom_range(20000, 45000);
			endcase
			// Upper data bits are don't-care and sometimes carry junk.
			write_reg(REG_POP_SIZE, $urandom_range(0, 3) == 0 ?
				DATA_W'({$urandom, 9'h0} | pop) : pop);
			write_reg(REG_AVG_FITNESS, $urandom_range(0, 3) == 0 ?
				DATA_W'({$urandom, 16'h0} | avg) : avg);
			send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
			if (phase == 1) begin
				hold_outputs = 1'b1;
				send_gap_pct = 0;
			end
			no_idle = (requests_sent >= 1350);
			phase_len = $urandom_range(20, 80);
			for (int i = 0; i < phase_len; i++) begin
				// Once, stop halfway and let every pick drain before going on.
				if (phase == 3 && i == phase_len / 2) quiesce();
				send(random_request(30));
			end
			phase++;
		end

		// Wait out the last picks and make sure nothing extra shows up.
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (sb.pending() != 0) sb.report_mismatch("picks still expected at the end");
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rws_pkg.sv
rtl/rws_regs.sv
rtl/rws_ctrl.sv
rtl/rws_datapath.sv
rtl/roulette_wheel_selector.sv
verif/roulette_wheel_selector_test.sv
